@@ src/rk4p_pkg.sv @@
// Package for the RK4 pendulum integrator: payload types, datapath commands,
// fixed-point constants, saturation and the CORDIC arctangent table.
// No dependencies.
package rk4p_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int FRAC_BITS    = 28;
   localparam int CORDIC_ITERS = 30;
   localparam int MUL_A_W      = 34;
   localparam int MUL_B_W      = 32;
   localparam int PROD_W       = MUL_A_W + MUL_B_W;
   localparam int WIDE_W       = 48;
   localparam int CORDIC_W     = 34;

   // one sixth as (2^33 + RECIP6_LO) / 2^36, exact for dividends below 2^35
   localparam logic [MUL_B_W-1:0] RECIP6_LO       = 32'hAAAAAAAB;
   localparam int                 RECIP6_HI_SHIFT = 33;
   localparam int                 RECIP6_SHIFT    = 36;

   localparam logic [31:0] OMEGA_RESET = 32'd2630667468;
   localparam logic [23:0] STEP_RESET  = 24'd1677722;

   localparam logic signed [CORDIC_W-1:0] PI_FX     = 34'sd843314857;
   localparam logic signed [CORDIC_W-1:0] HALF_PI   = 34'sd421657428;
   localparam logic signed [CORDIC_W-1:0] TWO_PI    = 34'sd1686629713;
   localparam logic signed [CORDIC_W-1:0] GAIN_Q30  = 34'sd652032874;

   localparam logic [0:0] CSR_OMEGA = 1'b0;
   localparam logic [0:0] CSR_STEP  = 1'b1;

   localparam logic OPC_LOAD = 1'b0;
   localparam logic OPC_STEP = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] initial_angle;
      logic signed [31:0] initial_velocity;
   } req_type;

   typedef struct packed {
      logic [31:0]        step_index;
      logic signed [31:0] angle_out;
      logic signed [31:0] velocity_out;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_IDLE, OP_LOAD, OP_START, OP_TA_MUL, OP_TA_ADD, OP_TV_MUL, OP_TV_ADD,
      OP_SIN_INIT, OP_SIN_ITER, OP_ACC_MUL, OP_ACC_ST, OP_FA_MUL, OP_FV_MUL,
      OP_DIV, OP_FA_ST, OP_FV_ST
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] stage;
      logic [4:0] iter;
   } dp_cmd_type;

   function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = {{(WIDE_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[DATA_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[DATA_WIDTH-1:0];
      end
      return v[DATA_WIDTH-1:0];
   endfunction

   function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0:    return 34'sd843314857;
         5'd1:    return 34'sd497837829;
         5'd2:    return 34'sd263043837;
         5'd3:    return 34'sd133525159;
         5'd4:    return 34'sd67021687;
         5'd5:    return 34'sd33543516;
         5'd6:    return 34'sd16775851;
         5'd7:    return 34'sd8388437;
         5'd8:    return 34'sd4194283;
         5'd9:    return 34'sd2097149;
         default: return CORDIC_W'(34'sd1048576 >>> (i - 5'd10));
      endcase
   endfunction

endpackage

@@ src/rk4p_ctrl.sv @@
// Sequencer for the RK4 pendulum integrator: handshakes and step schedule.
// Depends on rk4p_pkg; drives rk4p_dp through a command struct.
module rk4p_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rk4p_pkg::dp_cmd_type cmd
);

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_TA_MUL   = 15'b000000000000010,
      S_TA_ADD   = 15'b000000000000100,
      S_TV_MUL   = 15'b000000000001000,
      S_TV_ADD   = 15'b000000000010000,
      S_SIN_INIT = 15'b000000000100000,
      S_SIN_ITER = 15'b000000001000000,
      S_ACC_MUL  = 15'b000000010000000,
      S_ACC_ST   = 15'b000000100000000,
      S_FA_MUL   = 15'b000001000000000,
      S_FA_DIV   = 15'b000010000000000,
      S_FA_ST    = 15'b000100000000000,
      S_FV_MUL   = 15'b001000000000000,
      S_FV_DIV   = 15'b010000000000000,
      S_FV_ST    = 15'b100000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] stage_ff, stage_in;
   logic [4:0] iter_ff, iter_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = rk4p_pkg::OP_IDLE;
      cmd.stage    = stage_ff;
      cmd.iter     = iter_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == rk4p_pkg::OPC_LOAD) begin
                  cmd.op = rk4p_pkg::OP_LOAD;
               end else begin
                  cmd.op       = rk4p_pkg::OP_START;
                  rsp_valid_in = 1'b1;
                  stage_in     = 2'd0;
                  state_in     = S_SIN_INIT;
               end
            end
         end
         S_TA_MUL: begin
            cmd.op   = rk4p_pkg::OP_TA_MUL;
            state_in = S_TA_ADD;
         end
         S_TA_ADD: begin
            cmd.op   = rk4p_pkg::OP_TA_ADD;
            state_in = S_TV_MUL;
         end
         S_TV_MUL: begin
            cmd.op   = rk4p_pkg::OP_TV_MUL;
            state_in = S_TV_ADD;
         end
         S_TV_ADD: begin
            cmd.op   = rk4p_pkg::OP_TV_ADD;
            state_in = S_SIN_INIT;
         end
         S_SIN_INIT: begin
            cmd.op   = rk4p_pkg::OP_SIN_INIT;
            iter_in  = 5'd0;
            state_in = S_SIN_ITER;
         end
         S_SIN_ITER: begin
            cmd.op  = rk4p_pkg::OP_SIN_ITER;
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(rk4p_pkg::CORDIC_ITERS - 1)) begin
               state_in = S_ACC_MUL;
            end
         end
         S_ACC_MUL: begin
            cmd.op   = rk4p_pkg::OP_ACC_MUL;
            state_in = S_ACC_ST;
         end
         S_ACC_ST: begin
            cmd.op = rk4p_pkg::OP_ACC_ST;
            if (stage_ff == 2'd3) begin
               state_in = S_FA_MUL;
            end else begin
               stage_in = stage_ff + 2'd1;
               state_in = S_TA_MUL;
            end
         end
         S_FA_MUL: begin
            cmd.op   = rk4p_pkg::OP_FA_MUL;
            state_in = S_FA_DIV;
         end
         S_FA_DIV: begin
            cmd.op   = rk4p_pkg::OP_DIV;
            state_in = S_FA_ST;
         end
         S_FA_ST: begin
            cmd.op   = rk4p_pkg::OP_FA_ST;
            state_in = S_FV_MUL;
         end
         S_FV_MUL: begin
            cmd.op   = rk4p_pkg::OP_FV_MUL;
            state_in = S_FV_DIV;
         end
         S_FV_DIV: begin
            cmd.op   = rk4p_pkg::OP_DIV;
            state_in = S_FV_ST;
         end
         S_FV_ST: begin
            cmd.op   = rk4p_pkg::OP_FV_ST;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stage_ff     <= 2'd0;
         iter_ff      <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/rk4p_dp.sv @@
// Datapath for the RK4 pendulum integrator: state, slope accumulators,
// shared multiplier, CORDIC sine and divide-by-six. Depends on rk4p_pkg.
module rk4p_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  rk4p_pkg::dp_cmd_type cmd,
   input  rk4p_pkg::req_type    req_data,
   input  logic [31:0]          omega_sq,
   input  logic [23:0]          step_size,
   output rk4p_pkg::rsp_type    rsp_data
);

   localparam int DW = rk4p_pkg::DATA_WIDTH;
   localparam int WW = rk4p_pkg::WIDE_W;
   localparam int CW = rk4p_pkg::CORDIC_W;
   localparam int PW = rk4p_pkg::PROD_W;
   localparam int AW = rk4p_pkg::MUL_A_W;
   localparam int BW = rk4p_pkg::MUL_B_W;
   localparam int QW = PW + 2;

   logic signed [DW-1:0]   ang_ff, ang_in, vel_ff, vel_in;
   logic [31:0]            cnt_ff, cnt_in;
   logic signed [DW-1:0]   ta_ff, ta_in, da_ff, da_in, dv_ff, dv_in;
   logic signed [DW+2:0]   sum_a_ff, sum_a_in, sum_v_ff, sum_v_in;
   logic signed [CW-1:0]   cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [PW-1:0]          prod_ff;
   logic                   neg_ff, neg_in;
   logic [AW-1:0]          quot_ff, quot_in;
   rk4p_pkg::rsp_type      rsp_ff, rsp_in;
   logic                   mul_en;
   logic [AW-1:0]          mul_a;
   logic [BW-1:0]          mul_b;

   function automatic logic [AW-1:0] mag32(input logic signed [DW-1:0] v);
      return v[DW-1] ? AW'(-{{(AW-DW){v[DW-1]}}, v}) : AW'(v);
   endfunction

   function automatic logic [AW-1:0] mag35(input logic signed [DW+2:0] v);
      logic signed [DW+2:0] n;
      n = -v;
      return v[DW+2] ? n[AW-1:0] : v[AW-1:0];
   endfunction

   assign rsp_data = rsp_ff;

   always_comb begin
      logic signed [WW-1:0] m;
      logic signed [WW-1:0] t;
      logic signed [DW-1:0] r32;
      logic signed [CW-1:0] r;
      logic signed [CW-1:0] sh_x, sh_y;
      logic [QW-1:0]        qf;
      logic [4:0]           ci;
      ang_in   = ang_ff;
      vel_in   = vel_ff;
      cnt_in   = cnt_ff;
      ta_in    = ta_ff;
      da_in    = da_ff;
      dv_in    = dv_ff;
      sum_a_in = sum_a_ff;
      sum_v_in = sum_v_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      neg_in   = neg_ff;
      quot_in  = quot_ff;
      rsp_in   = rsp_ff;
      mul_en   = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      m        = '0;
      t        = '0;
      r32      = '0;
      r        = '0;
      qf       = '0;
      ci       = cmd.iter;
      sh_x     = cx_ff >>> ci;
      sh_y     = cy_ff >>> ci;
      case (cmd.op)
         rk4p_pkg::OP_LOAD: begin
            ang_in = req_data.initial_angle;
            vel_in = req_data.initial_velocity;
            cnt_in = '0;
         end
         rk4p_pkg::OP_START: begin
            rsp_in.step_index   = cnt_ff;
            rsp_in.angle_out    = ang_ff;
            rsp_in.velocity_out = vel_ff;
            da_in    = vel_ff;
            sum_a_in = (DW+3)'(vel_ff);
         end
         rk4p_pkg::OP_TA_MUL, rk4p_pkg::OP_TV_MUL: begin
            r32    = (cmd.op == rk4p_pkg::OP_TA_MUL) ? da_ff : dv_ff;
            mul_en = 1'b1;
            mul_a  = mag32(r32);
            mul_b  = BW'(step_size);
            neg_in = r32[DW-1];
         end
         rk4p_pkg::OP_TA_ADD, rk4p_pkg::OP_TV_ADD: begin
            m = (cmd.stage == 2'd3) ? WW'(prod_ff[55:24]) : WW'(prod_ff[56:25]);
            if (neg_ff) begin
               m = -m;
            end
            if (cmd.op == rk4p_pkg::OP_TA_ADD) begin
               ta_in = rk4p_pkg::sat(WW'(ang_ff) + m);
            end else begin
               r32   = rk4p_pkg::sat(WW'(vel_ff) + m);
               da_in = r32;
               if (cmd.stage == 2'd3) begin
                  sum_a_in = sum_a_ff + (DW+3)'(r32);
               end else begin
                  sum_a_in = sum_a_ff + ((DW+3)'(r32) <<< 1);
               end
            end
         end
         rk4p_pkg::OP_SIN_INIT: begin
            r = (cmd.stage == 2'd0) ? CW'(ang_ff) : CW'(ta_ff);
            if (r >= rk4p_pkg::TWO_PI) begin
               r = r - rk4p_pkg::TWO_PI;
            end else if (r <= -rk4p_pkg::TWO_PI) begin
               r = r + rk4p_pkg::TWO_PI;
            end
            if (r > rk4p_pkg::PI_FX) begin
               r = r - rk4p_pkg::TWO_PI;
            end else if (r < -rk4p_pkg::PI_FX) begin
               r = r + rk4p_pkg::TWO_PI;
            end
            if (r > rk4p_pkg::HALF_PI) begin
               r = rk4p_pkg::PI_FX - r;
            end else if (r < -rk4p_pkg::HALF_PI) begin
               r = -rk4p_pkg::PI_FX - r;
            end
            cx_in = rk4p_pkg::GAIN_Q30;
            cy_in = '0;
            cz_in = r <<< (30 - rk4p_pkg::FRAC_BITS);
         end
         rk4p_pkg::OP_SIN_ITER: begin
            if (!cz_ff[CW-1]) begin
               cx_in = cx_ff - sh_y;
               cy_in = cy_ff + sh_x;
               cz_in = cz_ff - rk4p_pkg::atan_q30(ci);
            end else begin
               cx_in = cx_ff + sh_y;
               cy_in = cy_ff - sh_x;
               cz_in = cz_ff + rk4p_pkg::atan_q30(ci);
            end
         end
         rk4p_pkg::OP_ACC_MUL: begin
            r      = cy_ff >>> (30 - rk4p_pkg::FRAC_BITS);
            r32    = r[DW-1:0];
            mul_en = 1'b1;
            mul_a  = mag32(r32);
            mul_b  = omega_sq;
            neg_in = r32[DW-1];
         end
         rk4p_pkg::OP_ACC_ST: begin
            m = WW'(prod_ff[63:24]);
            if (neg_ff) begin
               m = -m;
            end
            r32   = rk4p_pkg::sat(m);
            r32   = rk4p_pkg::sat(-WW'(r32));
            dv_in = r32;
            if (cmd.stage == 2'd0) begin
               sum_v_in = (DW+3)'(r32);
            end else if (cmd.stage == 2'd3) begin
               sum_v_in = sum_v_ff + (DW+3)'(r32);
            end else begin
               sum_v_in = sum_v_ff + ((DW+3)'(r32) <<< 1);
            end
         end
         rk4p_pkg::OP_FA_MUL, rk4p_pkg::OP_FV_MUL: begin
            mul_en  = 1'b1;
            mul_b   = BW'(step_size);
            quot_in = '0;
            if (cmd.op == rk4p_pkg::OP_FA_MUL) begin
               mul_a  = mag35(sum_a_ff);
               neg_in = sum_a_ff[DW+2];
            end else begin
               mul_a  = mag35(sum_v_ff);
               neg_in = sum_v_ff[DW+2];
            end
         end
         rk4p_pkg::OP_DIV: begin
            mul_en  = 1'b1;
            mul_a   = prod_ff[57:24];
            mul_b   = rk4p_pkg::RECIP6_LO;
            quot_in = prod_ff[57:24];
         end
         rk4p_pkg::OP_FA_ST, rk4p_pkg::OP_FV_ST: begin
            qf = {2'b00, prod_ff} + ({{(QW-AW){1'b0}}, quot_ff} << rk4p_pkg::RECIP6_HI_SHIFT);
            m  = WW'(qf[QW-1:rk4p_pkg::RECIP6_SHIFT]);
            if (neg_ff) begin
               m = -m;
            end
            if (cmd.op == rk4p_pkg::OP_FA_ST) begin
               t      = WW'(ang_ff) + m;
               ang_in = rk4p_pkg::sat(t);
            end else begin
               t      = WW'(vel_ff) + m;
               vel_in = rk4p_pkg::sat(t);
               cnt_in = cnt_ff + 32'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff <= '0;
         vel_ff <= '0;
         cnt_ff <= '0;
      end else begin
         ang_ff <= ang_in;
         vel_ff <= vel_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ta_ff    <= ta_in;
      da_ff    <= da_in;
      dv_ff    <= dv_in;
      sum_a_ff <= sum_a_in;
      sum_v_ff <= sum_v_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      neg_ff   <= neg_in;
      quot_ff  <= quot_in;
      rsp_ff   <= rsp_in;
      if (mul_en) begin
         prod_ff <= PW'(mul_a) * PW'(mul_b);
      end
   end

endmodule

@@ src/rk4_pendulum_integrator.sv @@
// Top level of the RK4 pendulum integrator: configuration registers and
// instances of rk4p_ctrl and rk4p_dp. Depends on rk4p_pkg.
//
// Usage:
//   req_* carries one item per transfer: opcode 0 loads angle and velocity
//   and clears the step counter (no result); opcode 1 emits the step index,
//   angle and velocity held before the step on rsp_*, then integrates one
//   RK4 step of size step_size under omega_sq.
//   A step shows its result in the cycle after the transfer and keeps the
//   integrator busy until it is done, so the next transfer is taken only
//   after that: four sine evaluations (range reduction, 30 CORDIC
//   iterations, slope multiply and store), three stage updates (multiply
//   and add for angle and for velocity), and two final updates (multiply
//   by h, multiply by one sixth, store).
//   req_ready is high while the sequencer is idle and the result register
//   is empty or being drained; a stalled rsp_* holds the pending result and
//   the next step waits for it.
//   csr_* is an APB-style port: omega_sq at byte address 0, step_size at 4.
//   Reset clears angle, velocity and counter, loads the default registers
//   and drops any pending result.
module rk4_pendulum_integrator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rk4p_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rk4p_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [31:0]          omega_ff, omega_in;
   logic [23:0]          step_ff, step_in;
   logic                 csr_wr;
   rk4p_pkg::dp_cmd_type cmd;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      omega_in = omega_ff;
      step_in  = step_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            rk4p_pkg::CSR_OMEGA: omega_in = csr_pwdata;
            rk4p_pkg::CSR_STEP:  step_in  = csr_pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         rk4p_pkg::CSR_OMEGA: csr_prdata = omega_ff;
         rk4p_pkg::CSR_STEP:  csr_prdata = {8'd0, step_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         omega_ff <= rk4p_pkg::OMEGA_RESET;
         step_ff  <= rk4p_pkg::STEP_RESET;
      end else begin
         omega_ff <= omega_in;
         step_ff  <= step_in;
      end
   end

   rk4p_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_data.opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd)
   );

   rk4p_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .omega_sq  (omega_ff),
      .step_size (step_ff),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/rk4_pendulum_integrator_test.sv @@
// Testbench for rk4_pendulum_integrator: directed table then bursty random load/step
// traffic across several omega_sq/step_size settings, checked against a local RK4 model.
// Depends on rk4p_pkg and the RTL under src.
module rk4_pendulum_integrator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 260;
   localparam logic [2:0] ADDR_OMEGA = 3'd0;
   localparam logic [2:0] ADDR_STEP  = 3'd4;
   localparam logic OPC_LOAD = rk4p_pkg::OPC_LOAD;
   localparam logic OPC_STEP = rk4p_pkg::OPC_STEP;

   typedef struct {
      rk4p_pkg::req_type req;
      bit                typed;
      rk4p_pkg::rsp_type exp;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   rk4p_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rk4p_pkg::rsp_type rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rk4p_pkg::rsp_type pending_rsp[$];
   int          mismatch_count = 0;
   int          step_count = 0;
   int          load_count = 0;
   int          checked_count = 0;
   int          setting_count = 0;
   int          burst_left = 0;

   longint      model_angle;
   longint      model_velocity;
   logic [31:0] model_counter;
   longint unsigned model_omega;
   longint unsigned model_step;

   rk4_pendulum_integrator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned scaled_mag(longint unsigned ua, longint unsigned b,
                                                   int s);
      logic [127:0] p;
      p = ({64'd0, ua} * {64'd0, b}) >> s;
      if (p > (128'd1 << 62)) return 64'd1 << 62;
      return p[63:0];
   endfunction

   function automatic longint unsigned abs64(longint a);
      return (a < 0) ? longint'(-a) : a;
   endfunction

   function automatic longint scale_signed(longint a, longint unsigned b, int s);
      longint m;
      m = longint'(scaled_mag(abs64(a), b, s));
      return clamp32((a < 0) ? -m : m);
   endfunction

   function automatic longint cordic_sine(longint a);
      longint r, x, y, z, nx, pi_l, half_l, two_l;
      pi_l = longint'(rk4p_pkg::PI_FX);
      half_l = longint'(rk4p_pkg::HALF_PI);
      two_l = longint'(rk4p_pkg::TWO_PI);
      r = a % two_l;
      x = longint'(rk4p_pkg::GAIN_Q30);
      y = 0;
      if (r > pi_l) r -= two_l;
      else if (r < -pi_l) r += two_l;
      if (r > half_l) r = pi_l - r;
      else if (r < -half_l) r = -pi_l - r;
      z = r * (64'sd1 << (30 - rk4p_pkg::FRAC_BITS));
      for (int i = 0; i < rk4p_pkg::CORDIC_ITERS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(rk4p_pkg::atan_q30(5'(i)));
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(rk4p_pkg::atan_q30(5'(i)));
         end
         x = nx;
      end
      return y >>> (30 - rk4p_pkg::FRAC_BITS);
   endfunction

   function automatic longint pendulum_accel(longint a);
      return clamp32(-scale_signed(cordic_sine(a), model_omega, 24));
   endfunction

   function automatic longint weighted_update(longint base, longint s1, longint s2,
                                              longint s3, longint s4);
      longint sum, m;
      sum = s1 + 2 * s2 + 2 * s3 + s4;
      m = longint'(scaled_mag(abs64(sum), model_step, 24) / 6);
      return clamp32(base + ((sum < 0) ? -m : m));
   endfunction

   function automatic bit predict_pendulum(rk4p_pkg::req_type r, output rk4p_pkg::rsp_type o);
      longint a, v, ta, tv;
      longint slope[8];
      int s;
      a = model_angle;
      v = model_velocity;
      o = '0;
      if (r.opcode == OPC_LOAD) begin
         model_angle = longint'(r.initial_angle);
         model_velocity = longint'(r.initial_velocity);
         model_counter = '0;
         return 1'b0;
      end
      o.step_index = model_counter;
      o.angle_out = a[31:0];
      o.velocity_out = v[31:0];
      slope[0] = v;
      slope[1] = pendulum_accel(a);
      for (int k = 1; k < 4; k++) begin
         s = (k == 3) ? 24 : 25;
         ta = clamp32(a + scale_signed(slope[2*k-2], model_step, s));
         tv = clamp32(v + scale_signed(slope[2*k-1], model_step, s));
         slope[2*k] = tv;
         slope[2*k+1] = pendulum_accel(ta);
      end
      model_angle = weighted_update(a, slope[0], slope[2], slope[4], slope[6]);
      model_velocity = weighted_update(v, slope[1], slope[3], slope[5], slope[7]);
      model_counter = model_counter + 32'd1;
      return 1'b1;
   endfunction

   task automatic transfer_req(rk4p_pkg::req_type r, bit typed, rk4p_pkg::rsp_type typed_exp);
      rk4p_pkg::rsp_type o;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      if (predict_pendulum(r, o)) begin
         pending_rsp.push_back(typed ? typed_exp : o);
         step_count++;
      end else begin
         load_count++;
      end
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_OMEGA) model_omega = value;
      else if (addr == ADDR_STEP) model_step = value[23:0];
      @(posedge clock);
   endtask

   task automatic apply_setting(logic [31:0] omega, logic [23:0] h);
      drain_and_settle();
      csr_write(ADDR_OMEGA, omega);
      csr_write(ADDR_STEP, {8'd0, h});
      setting_count++;
   endtask

   task automatic random_traffic(int count);
      rk4p_pkg::req_type r;
      for (int n = 0; n < count; n++) begin
         r.opcode = ($urandom_range(0, 9) == 0) ? OPC_LOAD : OPC_STEP;
         case ($urandom_range(0, 3))
            0: begin
               r.initial_angle = $urandom;
               r.initial_velocity = $urandom;
            end
            default: begin
               r.initial_angle = 32'($signed($urandom_range(0, 32'h7FFFFFFF))) >>> 1;
               r.initial_angle = $urandom_range(0, 1) ? r.initial_angle : -r.initial_angle;
               r.initial_velocity = 32'($signed($urandom_range(0, 32'h0FFFFFFF)));
               r.initial_velocity = $urandom_range(0, 1) ? r.initial_velocity
                                                         : -r.initial_velocity;
            end
         endcase
         transfer_req(r, 1'b0, '0);
         pace_sender();
      end
   endtask

   always @(posedge clock) begin
      if (reset || ($time / 6000) % 2 == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      rk4p_pkg::rsp_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            exp = pending_rsp.pop_front();
            checked_count++;
            if (rsp_data.step_index !== exp.step_index ||
                rsp_data.angle_out !== exp.angle_out ||
                rsp_data.velocity_out !== exp.velocity_out) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: index %h/%h angle %h/%h velocity %h/%h (exp/act)",
                           exp.step_index, rsp_data.step_index, exp.angle_out,
                           rsp_data.angle_out, exp.velocity_out, rsp_data.velocity_out);
            end
         end
      end
   end

   initial begin
      #15ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      table_row_type rows[$];
      model_angle = 0;
      model_velocity = 0;
      model_counter = '0;
      model_omega = rk4p_pkg::OMEGA_RESET;
      model_step = rk4p_pkg::STEP_RESET;
      rows = '{
         '{'{OPC_STEP, 32'sd0, 32'sd0}, 1'b1, '{32'd0, 32'sd0, 32'sd0}},
         '{'{OPC_LOAD, 32'h7FFFFFFF, 32'h80000000}, 1'b0, '0},
         '{'{OPC_STEP, 32'sd0, 32'sd0}, 1'b1, '{32'd0, 32'h7FFFFFFF, 32'h80000000}},
         '{'{OPC_STEP, 32'sd0, 32'sd0}, 1'b0, '0},
         '{'{OPC_LOAD, 32'h80000000, 32'h7FFFFFFF}, 1'b0, '0},
         '{'{OPC_STEP, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1, '{32'd0, 32'h80000000, 32'h7FFFFFFF}},
         '{'{OPC_STEP, 32'sd0, 32'sd0}, 1'b0, '0},
         '{'{OPC_LOAD, 32'sd0, 32'sd0}, 1'b0, '0},
         '{'{OPC_STEP, 32'sd0, 32'sd0}, 1'b1, '{32'd0, 32'sd0, 32'sd0}},
         '{'{OPC_STEP, 32'sd0, 32'sd0}, 1'b0, '0},
         '{'{OPC_LOAD, 32'sd421657428, 32'sd0}, 1'b0, '0},
         '{'{OPC_STEP, 32'sd0, 32'sd0}, 1'b0, '0},
         '{'{OPC_STEP, 32'sd0, 32'sd0}, 1'b0, '0},
         '{'{OPC_LOAD, -32'sd843314857, 32'sd268435456}, 1'b0, '0},
         '{'{OPC_STEP, 32'sd0, 32'sd0}, 1'b0, '0},
         '{'{OPC_LOAD, 32'hAAAAAAAA, 32'h55555555}, 1'b0, '0},
         '{'{OPC_STEP, 32'sd0, 32'sd0}, 1'b0, '0},
         '{'{OPC_LOAD, 32'h55555555, 32'hAAAAAAAA}, 1'b0, '0},
         '{'{OPC_STEP, 32'sd0, 32'sd0}, 1'b0, '0},
         '{'{OPC_LOAD, -32'sd1, 32'sd1}, 1'b0, '0},
         '{'{OPC_STEP, 32'sd0, 32'sd0}, 1'b0, '0}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         transfer_req(rows[i].req, rows[i].typed, rows[i].exp);
         pace_sender();
      end
      random_traffic(150);
      apply_setting(32'hFFFFFFFF, 24'hFFFFFF);
      random_traffic(100);
      apply_setting(32'd0, 24'd1);
      random_traffic(80);
      apply_setting($urandom, 24'd0);
      random_traffic(60);
      apply_setting($urandom, 24'($urandom_range(1, 24'hFFFFFF)));
      random_traffic(80);
      apply_setting(rk4p_pkg::OMEGA_RESET, rk4p_pkg::STEP_RESET);
      random_traffic(80);
      drain_and_settle();
      $display("covered %0d steps and %0d loads over %0d register settings, %0d results checked",
               step_count, load_count, setting_count, checked_count);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatch_count,
                  pending_rsp.size());
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

@@ rk4_pendulum_integrator.f @@
src/rk4p_pkg.sv
src/rk4p_ctrl.sv
src/rk4p_dp.sv
src/rk4_pendulum_integrator.sv
tb/rk4_pendulum_integrator_test.sv
